/* rtl/detector_coincidence_builder_macros.svh */
// ----------------------------------------------------------------------------
// Coincidence builder assertion macros
// Concurrent assertion wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DETECTOR_COINCIDENCE_BUILDER_MACROS_SVH
`define DETECTOR_COINCIDENCE_BUILDER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define DCB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define DCB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/dcb_pkg.sv */
// ----------------------------------------------------------------------------
// Coincidence builder package
// Field widths, register reset values and the structs shared by the modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dcb_pkg;

    localparam int NUM_DETECTORS_DEF = 10;
    localparam int DT_BITS_DEF       = 16;
    localparam int QUEUE_DEPTH       = 2;

    localparam int CH_W       = 12;
    localparam int EN_W       = 16;
    localparam int TS_W       = 48;
    localparam int CFD_W      = 16;
    localparam int TIME_W     = TS_W + 1;
    localparam int WIN_W      = 16;
    localparam int IDX_OUT_W  = 4;
    localparam int DT_OUT_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CH_W-1:0]         DET_BASE_RST = 12'd600;
    localparam logic [CH_W-1:0]         REF_A_CH_RST = 12'd403;
    localparam logic [CH_W-1:0]         REF_B_CH_RST = 12'd503;
    localparam logic signed [WIN_W-1:0] WIN_A_LO_RST = -16'sd60;
    localparam logic signed [WIN_W-1:0] WIN_A_HI_RST = -16'sd10;
    localparam logic signed [WIN_W-1:0] WIN_B_LO_RST = -16'sd60;
    localparam logic signed [WIN_W-1:0] WIN_B_HI_RST = 16'sd60;

    typedef struct packed {
        logic [CH_W-1:0]         det_base;
        logic [CH_W-1:0]         ref_a_ch;
        logic [CH_W-1:0]         ref_b_ch;
        logic signed [WIN_W-1:0] win_a_lo;
        logic signed [WIN_W-1:0] win_a_hi;
        logic signed [WIN_W-1:0] win_b_lo;
        logic signed [WIN_W-1:0] win_b_hi;
    } cfg_t;

    typedef struct packed {
        logic              det_hit;
        logic [CH_W-1:0]   det_off;
        logic              ref_a_hit;
        logic              ref_b_hit;
        logic [EN_W-1:0]   energy;
        logic [TIME_W-1:0] hit_time;
        logic              last;
    } hit_entry_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0]       det_index;
        logic [EN_W-1:0]            det_energy;
        logic                       a_present;
        logic [EN_W-1:0]            a_energy;
        logic signed [DT_OUT_W-1:0] dt_a;
        logic                       a_in_window;
        logic                       b_present;
        logic [EN_W-1:0]            b_energy;
        logic signed [DT_OUT_W-1:0] dt_b;
        logic                       b_in_window;
        logic                       last;
    } result_t;

    typedef struct packed {
        logic emitting;
        logic pop;
    } back_status_t;

endpackage

`default_nettype wire

/* rtl/detector_coincidence_builder.sv */
// ----------------------------------------------------------------------------
// Detector coincidence builder
// Collects the first hit per detector and reference channel over one event
// and emits one timing record per fired detector at the event's last hit.
//
// Hit channel: in_valid/in_stall, transfer when in_valid && !in_stall. A
// two-entry queue takes one hit per cycle; in_stall rises only when it fills.
// The capture stage drains one hit per cycle outside of emission.
// Result channel: out_valid/out_stall, held in an output register; a stalled
// record holds and the emission sequencer waits behind it.
// Config channel: cfg_valid/cfg_ready, cfg_ready is always high; write only
// while no event is in flight.
// Emission: once the capture stage takes the last hit, the sequencer visits
// the detectors in order in ST_SCAN; one that fired passes on through ST_DIFF
// and ST_EMIT, where its record is loaded into the output register. An event
// with no detector fired yields no record.
// Reset clears the capture flags and reference captures, empties the queue
// and restores the register defaults; no clearing sweep is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "detector_coincidence_builder_macros.svh"

module detector_coincidence_builder #(
    parameter int NUM_DETECTORS = dcb_pkg::NUM_DETECTORS_DEF,
    parameter int DT_BITS       = dcb_pkg::DT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [dcb_pkg::CH_W-1:0]            hit_channel,
    input  logic [dcb_pkg::EN_W-1:0]            hit_energy,
    input  logic [dcb_pkg::TS_W-1:0]            hit_timestamp,
    input  logic [dcb_pkg::CFD_W-1:0]           hit_cfd,
    input  logic                                last_hit,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [dcb_pkg::IDX_OUT_W-1:0]       detector_index,
    output logic [dcb_pkg::EN_W-1:0]            detector_energy,
    output logic                                ref_a_present,
    output logic [dcb_pkg::EN_W-1:0]            ref_a_energy,
    output logic signed [dcb_pkg::DT_OUT_W-1:0] dt_a,
    output logic                                in_window_a,
    output logic                                ref_b_present,
    output logic [dcb_pkg::EN_W-1:0]            ref_b_energy,
    output logic signed [dcb_pkg::DT_OUT_W-1:0] dt_b,
    output logic                                in_window_b,
    output logic                                last_of_event,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dcb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dcb_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam logic [dcb_pkg::CFG_IDX_W-1:0] REG_DET_BASE = 3'd0;
    localparam logic [dcb_pkg::CFG_IDX_W-1:0] REG_REF_A_CH = 3'd1;
    localparam logic [dcb_pkg::CFG_IDX_W-1:0] REG_REF_B_CH = 3'd2;
    localparam logic [dcb_pkg::CFG_IDX_W-1:0] REG_WIN_A_LO = 3'd3;
    localparam logic [dcb_pkg::CFG_IDX_W-1:0] REG_WIN_A_HI = 3'd4;
    localparam logic [dcb_pkg::CFG_IDX_W-1:0] REG_WIN_B_LO = 3'd5;
    localparam logic [dcb_pkg::CFG_IDX_W-1:0] REG_WIN_B_HI = 3'd6;

    dcb_pkg::cfg_t         cfg_reg;
    dcb_pkg::hit_entry_t   wr_entry;
    dcb_pkg::hit_entry_t   q_data;
    dcb_pkg::result_t      result;
    dcb_pkg::back_status_t back_status;
    logic                  push;
    logic                  q_full;
    logic                  q_valid;
    logic                  pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.det_base <= dcb_pkg::DET_BASE_RST;
            cfg_reg.ref_a_ch <= dcb_pkg::REF_A_CH_RST;
            cfg_reg.ref_b_ch <= dcb_pkg::REF_B_CH_RST;
            cfg_reg.win_a_lo <= dcb_pkg::WIN_A_LO_RST;
            cfg_reg.win_a_hi <= dcb_pkg::WIN_A_HI_RST;
            cfg_reg.win_b_lo <= dcb_pkg::WIN_B_LO_RST;
            cfg_reg.win_b_hi <= dcb_pkg::WIN_B_HI_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DET_BASE: cfg_reg.det_base <= cfg_data[dcb_pkg::CH_W-1:0];
                REG_REF_A_CH: cfg_reg.ref_a_ch <= cfg_data[dcb_pkg::CH_W-1:0];
                REG_REF_B_CH: cfg_reg.ref_b_ch <= cfg_data[dcb_pkg::CH_W-1:0];
                REG_WIN_A_LO: cfg_reg.win_a_lo <= $signed(cfg_data);
                REG_WIN_A_HI: cfg_reg.win_a_hi <= $signed(cfg_data);
                REG_WIN_B_LO: cfg_reg.win_b_lo <= $signed(cfg_data);
                REG_WIN_B_HI: cfg_reg.win_b_hi <= $signed(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    dcb_front #(
        .NUM_DETECTORS (NUM_DETECTORS)
    ) u_front (
        .cfg           (cfg_reg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .hit_channel   (hit_channel),
        .hit_energy    (hit_energy),
        .hit_timestamp (hit_timestamp),
        .hit_cfd       (hit_cfd),
        .last_hit      (last_hit),
        .q_full        (q_full),
        .push          (push),
        .entry         (wr_entry)
    );

    dcb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_entry),
        .full    (q_full),
        .q_valid (q_valid),
        .pop     (pop),
        .rd_data (q_data)
    );

    dcb_back #(
        .NUM_DETECTORS (NUM_DETECTORS),
        .DT_BITS       (DT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop),
        .res_valid (out_valid),
        .res_stall (out_stall),
        .result    (result),
        .status    (back_status)
    );

    assign detector_index  = result.det_index;
    assign detector_energy = result.det_energy;
    assign ref_a_present   = result.a_present;
    assign ref_a_energy    = result.a_energy;
    assign dt_a            = result.dt_a;
    assign in_window_a     = result.a_in_window;
    assign ref_b_present   = result.b_present;
    assign ref_b_energy    = result.b_energy;
    assign dt_b            = result.dt_b;
    assign in_window_b     = result.b_in_window;
    assign last_of_event   = result.last;

    `DCB_ASSERT_SAME(a_no_pop_while_emitting, back_status.emitting, !back_status.pop, "hit taken during emission")
    `DCB_ASSERT_NEXT(a_last_hit_starts_scan, back_status.pop && q_data.last, back_status.emitting, "last hit did not start emission")
    `DCB_ASSERT_SAME(a_open_event_keeps_emitting, out_valid && !last_of_event, back_status.emitting, "event closed before its last record")
    `DCB_ASSERT_SAME(a_record_from_sequencer, $rose(out_valid), $past(back_status.emitting), "record loaded outside emission")

endmodule

`default_nettype wire

/* rtl/dcb_front.sv */
// ----------------------------------------------------------------------------
// Coincidence builder front end
// Accepts hits, forms the corrected time and classifies the channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcb_front #(
    parameter int NUM_DETECTORS = dcb_pkg::NUM_DETECTORS_DEF
) (
    input  dcb_pkg::cfg_t                cfg,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [dcb_pkg::CH_W-1:0]     hit_channel,
    input  logic [dcb_pkg::EN_W-1:0]     hit_energy,
    input  logic [dcb_pkg::TS_W-1:0]     hit_timestamp,
    input  logic [dcb_pkg::CFD_W-1:0]    hit_cfd,
    input  logic                         last_hit,
    input  logic                         q_full,
    output logic                         push,
    output dcb_pkg::hit_entry_t          entry
);

    localparam logic [dcb_pkg::CH_W:0] NUM_DET_LIM = (dcb_pkg::CH_W + 1)'(NUM_DETECTORS);

    logic [dcb_pkg::CH_W-1:0] offset;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;
    assign offset   = hit_channel - cfg.det_base;

    always_comb
    begin
        entry.det_hit   = (hit_channel >= cfg.det_base) && ({1'b0, offset} < NUM_DET_LIM);
        entry.det_off   = offset;
        entry.ref_a_hit = (hit_channel == cfg.ref_a_ch);
        entry.ref_b_hit = (hit_channel == cfg.ref_b_ch);
        entry.energy    = hit_energy;
        entry.hit_time  = {1'b0, hit_timestamp}
                        + {{(dcb_pkg::TIME_W - dcb_pkg::CFD_W){1'b0}}, hit_cfd};
        entry.last      = last_hit;
    end

endmodule

`default_nettype wire

/* rtl/dcb_queue.sv */
// ----------------------------------------------------------------------------
// Coincidence builder hit queue
// Short FIFO of classified hits between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcb_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  dcb_pkg::hit_entry_t wr_data,
    output logic                full,
    output logic                q_valid,
    input  logic                pop,
    output dcb_pkg::hit_entry_t rd_data
);

    localparam int DEPTH = dcb_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    dcb_pkg::hit_entry_t entry_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;

    assign full    = (count_reg == FULL_CNT);
    assign q_valid = (count_reg != '0);
    assign rd_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/dcb_back.sv */
// ----------------------------------------------------------------------------
// Coincidence builder back end
// Captures first hits per channel, then scans detectors and emits records.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcb_back #(
    parameter int NUM_DETECTORS = dcb_pkg::NUM_DETECTORS_DEF,
    parameter int DT_BITS       = dcb_pkg::DT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dcb_pkg::cfg_t         cfg,
    input  logic                  q_valid,
    input  dcb_pkg::hit_entry_t   q_data,
    output logic                  pop,
    output logic                  res_valid,
    input  logic                  res_stall,
    output dcb_pkg::result_t      result,
    output dcb_pkg::back_status_t status
);

    localparam int IDX_W  = (NUM_DETECTORS > 1) ? $clog2(NUM_DETECTORS) : 1;
    localparam int DIFF_W = dcb_pkg::TIME_W + 1;
    localparam int EN_W   = dcb_pkg::EN_W;
    localparam int TIME_W = dcb_pkg::TIME_W;
    localparam int WIN_W  = dcb_pkg::WIN_W;
    localparam int OUT_W  = dcb_pkg::DT_OUT_W;
    localparam logic [IDX_W-1:0]         LAST_IDX = IDX_W'(NUM_DETECTORS - 1);
    localparam logic [NUM_DETECTORS-1:0] BIT0     = NUM_DETECTORS'(1);
    localparam logic signed [DIFF_W-1:0] DT_MAX   = (DIFF_W'(1) <<< (DT_BITS - 1)) - DIFF_W'(1);
    localparam logic signed [DIFF_W-1:0] DT_MIN   = ~DT_MAX;

    typedef enum logic [1:0] {
        ST_CAPTURE,
        ST_SCAN,
        ST_DIFF,
        ST_EMIT
    } state_t;

    state_t                     state_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic [NUM_DETECTORS-1:0]   det_valid_reg;
    logic [EN_W-1:0]            det_energy_reg [NUM_DETECTORS];
    logic [TIME_W-1:0]          det_time_reg   [NUM_DETECTORS];
    logic [EN_W-1:0]            rd_energy_reg;
    logic [TIME_W-1:0]          rd_time_reg;
    logic                       ref_a_valid_reg;
    logic [EN_W-1:0]            ref_a_energy_reg;
    logic [TIME_W-1:0]          ref_a_time_reg;
    logic                       ref_b_valid_reg;
    logic [EN_W-1:0]            ref_b_energy_reg;
    logic [TIME_W-1:0]          ref_b_time_reg;
    logic signed [DIFF_W-1:0]   dt_a_full_reg;
    logic signed [DIFF_W-1:0]   dt_b_full_reg;
    logic                       res_valid_reg;
    dcb_pkg::result_t           res_reg;

    logic                       out_free;
    logic                       det_write;
    logic [IDX_W-1:0]           cap_idx;
    logic [NUM_DETECTORS-1:0]   remaining;
    logic                       pres_a;
    logic                       pres_b;
    logic                       win_a;
    logic                       win_b;
    logic signed [DIFF_W-1:0]   win_a_lo;
    logic signed [DIFF_W-1:0]   win_a_hi;
    logic signed [DIFF_W-1:0]   win_b_lo;
    logic signed [DIFF_W-1:0]   win_b_hi;
    logic [IDX_W+dcb_pkg::IDX_OUT_W-1:0] idx_ext;

    function automatic logic [OUT_W-1:0] sat_dt(input logic signed [DIFF_W-1:0] d);
        logic [DT_BITS-1:0]       s;
        logic [DT_BITS+OUT_W-1:0] e;
        if (d > DT_MAX)
        begin
            s = DT_MAX[DT_BITS-1:0];
        end
        else if (d < DT_MIN)
        begin
            s = DT_MIN[DT_BITS-1:0];
        end
        else
        begin
            s = d[DT_BITS-1:0];
        end
        e = {{OUT_W{1'b0}}, s};
        return e[OUT_W-1:0];
    endfunction

    assign pop       = q_valid && (state_reg == ST_CAPTURE);
    assign out_free  = !res_valid_reg || !res_stall;
    assign cap_idx   = q_data.det_off[IDX_W-1:0];
    assign det_write = pop && q_data.det_hit && !det_valid_reg[cap_idx];
    assign remaining = det_valid_reg & ~(BIT0 << idx_reg);
    assign pres_a    = ref_a_valid_reg && (ref_a_energy_reg != '0);
    assign pres_b    = ref_b_valid_reg && (ref_b_energy_reg != '0);
    assign win_a_lo  = $signed({{(DIFF_W - WIN_W){cfg.win_a_lo[WIN_W-1]}}, cfg.win_a_lo});
    assign win_a_hi  = $signed({{(DIFF_W - WIN_W){cfg.win_a_hi[WIN_W-1]}}, cfg.win_a_hi});
    assign win_b_lo  = $signed({{(DIFF_W - WIN_W){cfg.win_b_lo[WIN_W-1]}}, cfg.win_b_lo});
    assign win_b_hi  = $signed({{(DIFF_W - WIN_W){cfg.win_b_hi[WIN_W-1]}}, cfg.win_b_hi});
    assign win_a     = pres_a && (dt_a_full_reg >= win_a_lo) && (dt_a_full_reg <= win_a_hi);
    assign win_b     = pres_b && (dt_b_full_reg >= win_b_lo) && (dt_b_full_reg <= win_b_hi);
    assign idx_ext   = {{dcb_pkg::IDX_OUT_W{1'b0}}, idx_reg};

    assign res_valid       = res_valid_reg;
    assign result          = res_reg;
    assign status.emitting = (state_reg != ST_CAPTURE);
    assign status.pop      = pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CAPTURE;
            idx_reg          <= '0;
            det_valid_reg    <= '0;
            ref_a_valid_reg  <= 1'b0;
            ref_a_energy_reg <= '0;
            ref_a_time_reg   <= '0;
            ref_b_valid_reg  <= 1'b0;
            ref_b_energy_reg <= '0;
            ref_b_time_reg   <= '0;
            dt_a_full_reg    <= '0;
            dt_b_full_reg    <= '0;
            res_valid_reg    <= 1'b0;
            res_reg          <= '0;
        end
        else
        begin
            if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CAPTURE:
                begin
                    if (pop)
                    begin
                        if (det_write)
                        begin
                            det_valid_reg[cap_idx] <= 1'b1;
                        end
                        if (q_data.ref_a_hit && !ref_a_valid_reg)
                        begin
                            ref_a_valid_reg  <= 1'b1;
                            ref_a_energy_reg <= q_data.energy;
                            ref_a_time_reg   <= q_data.hit_time;
                        end
                        if (q_data.ref_b_hit && !ref_b_valid_reg)
                        begin
                            ref_b_valid_reg  <= 1'b1;
                            ref_b_energy_reg <= q_data.energy;
                            ref_b_time_reg   <= q_data.hit_time;
                        end
                        if (q_data.last)
                        begin
                            state_reg <= ST_SCAN;
                            idx_reg   <= '0;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (det_valid_reg[idx_reg])
                    begin
                        state_reg <= ST_DIFF;
                    end
                    else if (idx_reg == LAST_IDX)
                    begin
                        state_reg        <= ST_CAPTURE;
                        ref_a_valid_reg  <= 1'b0;
                        ref_a_energy_reg <= '0;
                        ref_a_time_reg   <= '0;
                        ref_b_valid_reg  <= 1'b0;
                        ref_b_energy_reg <= '0;
                        ref_b_time_reg   <= '0;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_DIFF:
                begin
                    dt_a_full_reg <= $signed({1'b0, ref_a_time_reg}) - $signed({1'b0, rd_time_reg});
                    dt_b_full_reg <= $signed({1'b0, ref_b_time_reg}) - $signed({1'b0, rd_time_reg});
                    state_reg     <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        res_valid_reg          <= 1'b1;
                        res_reg.det_index      <= idx_ext[dcb_pkg::IDX_OUT_W-1:0];
                        res_reg.det_energy     <= rd_energy_reg;
                        res_reg.a_present      <= pres_a;
                        res_reg.a_energy       <= ref_a_energy_reg;
                        res_reg.dt_a           <= pres_a ? sat_dt(dt_a_full_reg) : '0;
                        res_reg.a_in_window    <= win_a;
                        res_reg.b_present      <= pres_b;
                        res_reg.b_energy       <= ref_b_energy_reg;
                        res_reg.dt_b           <= pres_b ? sat_dt(dt_b_full_reg) : '0;
                        res_reg.b_in_window    <= win_b;
                        res_reg.last           <= (remaining == '0);
                        det_valid_reg[idx_reg] <= 1'b0;
                        if (remaining == '0)
                        begin
                            state_reg        <= ST_CAPTURE;
                            ref_a_valid_reg  <= 1'b0;
                            ref_a_energy_reg <= '0;
                            ref_a_time_reg   <= '0;
                            ref_b_valid_reg  <= 1'b0;
                            ref_b_energy_reg <= '0;
                            ref_b_time_reg   <= '0;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                            idx_reg   <= idx_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_CAPTURE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (det_write)
        begin
            det_energy_reg[cap_idx] <= q_data.energy;
            det_time_reg[cap_idx]   <= q_data.hit_time;
        end
        if (state_reg == ST_SCAN)
        begin
            rd_energy_reg <= det_energy_reg[idx_reg];
            rd_time_reg   <= det_time_reg[idx_reg];
        end
    end

endmodule

`default_nettype wire

/* tb/sv/dcb_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coincidence builder testbench package
// Register map of the configuration channel, shared by the stimulus and the
// checker.
// ----------------------------------------------------------------------------
package dcb_tb_pkg;

    typedef enum logic [dcb_pkg::CFG_IDX_W-1:0] {
        REG_DET_BASE,
        REG_REF_A_CH,
        REG_REF_B_CH,
        REG_WIN_A_LO,
        REG_WIN_A_HI,
        REG_WIN_B_LO,
        REG_WIN_B_HI,
        REG_UNUSED
    } cfg_reg_e;

    localparam int NUM_REGS = 8;

endpackage

/* tb/sv/coincidence_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coincidence builder checker
// Watches the hit, record and configuration channels. Keeps its own copy of
// the first-hit capture per detector and reference, builds the expected
// records at each last hit and compares every record transfer, field by
// field, against the oldest expected record.
// ----------------------------------------------------------------------------
module coincidence_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic [dcb_pkg::CH_W-1:0]            hit_channel,
    input  logic [dcb_pkg::EN_W-1:0]            hit_energy,
    input  logic [dcb_pkg::TS_W-1:0]            hit_timestamp,
    input  logic [dcb_pkg::CFD_W-1:0]           hit_cfd,
    input  logic                                last_hit,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [dcb_pkg::IDX_OUT_W-1:0]       detector_index,
    input  logic [dcb_pkg::EN_W-1:0]            detector_energy,
    input  logic                                ref_a_present,
    input  logic [dcb_pkg::EN_W-1:0]            ref_a_energy,
    input  logic signed [dcb_pkg::DT_OUT_W-1:0] dt_a,
    input  logic                                in_window_a,
    input  logic                                ref_b_present,
    input  logic [dcb_pkg::EN_W-1:0]            ref_b_energy,
    input  logic signed [dcb_pkg::DT_OUT_W-1:0] dt_b,
    input  logic                                in_window_b,
    input  logic                                last_of_event,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [dcb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dcb_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                  mismatch_count,
    output int                                  records_outstanding
);

    import dcb_pkg::*;
    import dcb_tb_pkg::*;

    localparam int     NUM_DET = NUM_DETECTORS_DEF;
    localparam longint DT_MAX  = (longint'(1) << (DT_BITS_DEF - 1)) - 1;
    localparam longint DT_MIN  = -DT_MAX - 1;

    cfg_t              cfg;
    logic              det_fired [NUM_DET];
    logic [EN_W-1:0]   det_energy [NUM_DET];
    logic [TIME_W-1:0] det_time [NUM_DET];
    logic              ref_a_seen;
    logic [EN_W-1:0]   ref_a_first_energy;
    logic [TIME_W-1:0] ref_a_time;
    logic              ref_b_seen;
    logic [EN_W-1:0]   ref_b_first_energy;
    logic [TIME_W-1:0] ref_b_time;
    result_t           expected_records [$];

    task automatic clear_capture();
        for (int i = 0; i < NUM_DET; i++)
        begin
            det_fired[i]  = 1'b0;
            det_energy[i] = '0;
            det_time[i]   = '0;
        end
        ref_a_seen         = 1'b0;
        ref_a_first_energy = '0;
        ref_a_time         = '0;
        ref_b_seen         = 1'b0;
        ref_b_first_energy = '0;
        ref_b_time         = '0;
    endtask

    function automatic logic [DT_OUT_W-1:0] saturate(input logic signed [TIME_W:0] diff);
        if (diff > DT_MAX)
            return DT_OUT_W'(DT_MAX);
        else if (diff < DT_MIN)
            return DT_OUT_W'(DT_MIN);
        return diff[DT_OUT_W-1:0];
    endfunction

    task automatic check_field(input string field, input longint expv, input longint actv);
        if (expv != actv)
        begin
            $error("%s: expected %0d, actual %0d", field, expv, actv);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : predict_and_check
        logic [TIME_W-1:0]      hit_time;
        int                     det_slot;
        int                     final_det;
        logic                   a_on;
        logic                   b_on;
        logic signed [TIME_W:0] diff_a;
        logic signed [TIME_W:0] diff_b;
        result_t                rec;
        if (!rst_n)
        begin
            cfg = '{DET_BASE_RST, REF_A_CH_RST, REF_B_CH_RST,
                    WIN_A_LO_RST, WIN_A_HI_RST, WIN_B_LO_RST, WIN_B_HI_RST};
            clear_capture();
            expected_records.delete();
            mismatch_count = 0;
            records_outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_e'(cfg_index))
                    REG_DET_BASE: cfg.det_base = cfg_data[CH_W-1:0];
                    REG_REF_A_CH: cfg.ref_a_ch = cfg_data[CH_W-1:0];
                    REG_REF_B_CH: cfg.ref_b_ch = cfg_data[CH_W-1:0];
                    REG_WIN_A_LO: cfg.win_a_lo = cfg_data;
                    REG_WIN_A_HI: cfg.win_a_hi = cfg_data;
                    REG_WIN_B_LO: cfg.win_b_lo = cfg_data;
                    REG_WIN_B_HI: cfg.win_b_hi = cfg_data;
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                hit_time = TIME_W'(hit_timestamp) + TIME_W'(hit_cfd);
                det_slot = int'(hit_channel) - int'(cfg.det_base);
                if (det_slot >= 0 && det_slot < NUM_DET)
                begin
                    if (!det_fired[det_slot])
                    begin
                        det_fired[det_slot]  = 1'b1;
                        det_energy[det_slot] = hit_energy;
                        det_time[det_slot]   = hit_time;
                    end
                end
                if (hit_channel == cfg.ref_a_ch && !ref_a_seen)
                begin
                    ref_a_seen         = 1'b1;
                    ref_a_first_energy = hit_energy;
                    ref_a_time         = hit_time;
                end
                if (hit_channel == cfg.ref_b_ch && !ref_b_seen)
                begin
                    ref_b_seen         = 1'b1;
                    ref_b_first_energy = hit_energy;
                    ref_b_time         = hit_time;
                end

                if (last_hit)
                begin
                    final_det = -1;
                    for (int i = 0; i < NUM_DET; i++)
                        if (det_fired[i])
                            final_det = i;
                    a_on = ref_a_seen && ref_a_first_energy != '0;
                    b_on = ref_b_seen && ref_b_first_energy != '0;
                    for (int i = 0; i < NUM_DET; i++)
                    begin
                        if (det_fired[i])
                        begin
                            diff_a = $signed({1'b0, ref_a_time}) - $signed({1'b0, det_time[i]});
                            diff_b = $signed({1'b0, ref_b_time}) - $signed({1'b0, det_time[i]});
                            rec.det_index   = IDX_OUT_W'(i);
                            rec.det_energy  = det_energy[i];
                            rec.a_present   = a_on;
                            rec.a_energy    = ref_a_first_energy;
                            rec.dt_a        = a_on ? saturate(diff_a) : '0;
                            rec.a_in_window = a_on && diff_a >= $signed(cfg.win_a_lo)
                                                   && diff_a <= $signed(cfg.win_a_hi);
                            rec.b_present   = b_on;
                            rec.b_energy    = ref_b_first_energy;
                            rec.dt_b        = b_on ? saturate(diff_b) : '0;
                            rec.b_in_window = b_on && diff_b >= $signed(cfg.win_b_lo)
                                                   && diff_b <= $signed(cfg.win_b_hi);
                            rec.last        = (i == final_det);
                            expected_records.push_back(rec);
                        end
                    end
                    clear_capture();
                end
            end

            if (out_valid && !out_stall)
            begin
                if (expected_records.size() == 0)
                begin
                    $error("unexpected record transfer for detector %0d", detector_index);
                    mismatch_count++;
                end
                else
                begin
                    rec = expected_records.pop_front();
                    check_field("detector_index", rec.det_index, detector_index);
                    check_field("detector_energy", rec.det_energy, detector_energy);
                    check_field("ref_a_present", rec.a_present, ref_a_present);
                    check_field("ref_a_energy", rec.a_energy, ref_a_energy);
                    check_field("dt_a", $signed(rec.dt_a), $signed(dt_a));
                    check_field("in_window_a", rec.a_in_window, in_window_a);
                    check_field("ref_b_present", rec.b_present, ref_b_present);
                    check_field("ref_b_energy", rec.b_energy, ref_b_energy);
                    check_field("dt_b", $signed(rec.dt_b), $signed(dt_b));
                    check_field("in_window_b", rec.b_in_window, in_window_b);
                    check_field("last_of_event", rec.last, last_of_event);
                end
            end

            records_outstanding <= expected_records.size();
        end
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coincidence builder testbench
// Drives directed and random hit events through the builder under several
// register settings and idle patterns on both channels. The checker beside
// the block predicts and compares every record; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

    import dcb_pkg::*;
    import dcb_tb_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 48;
    localparam int STALL_LIMIT   = 2000;
    localparam int SECTIONS      = 9;
    localparam int SECTION_ITEMS = 45;

    localparam cfg_t WIDE_SETTING = '{12'd0, 12'd4095, 12'd5,
                                      16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000};
    localparam cfg_t TOP_SETTING  = '{12'd4086, 12'd4095, 12'd4095,
                                      16'h0000, 16'h0000, 16'h8000, 16'h8000};
    localparam cfg_t EDGE_SETTING = '{12'd4095, 12'd0, 12'd0,
                                      16'h7FFF, 16'h7FFF, 16'hFF9C, 16'h0064};

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 in_valid      = 1'b0;
    logic [CH_W-1:0]      hit_channel   = '0;
    logic [EN_W-1:0]      hit_energy    = '0;
    logic [TS_W-1:0]      hit_timestamp = '0;
    logic [CFD_W-1:0]     hit_cfd       = '0;
    logic                 last_hit      = 1'b0;
    logic                 out_stall     = 1'b0;
    logic                 cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    logic                        in_stall;
    logic                        out_valid;
    logic [IDX_OUT_W-1:0]        detector_index;
    logic [EN_W-1:0]             detector_energy;
    logic                        ref_a_present;
    logic [EN_W-1:0]             ref_a_energy;
    logic signed [DT_OUT_W-1:0]  dt_a;
    logic                        in_window_a;
    logic                        ref_b_present;
    logic [EN_W-1:0]             ref_b_energy;
    logic signed [DT_OUT_W-1:0]  dt_b;
    logic                        in_window_b;
    logic                        last_of_event;
    logic                        cfg_ready;

    int   mismatch_count;
    int   records_outstanding;
    int   send_idle_pct = 10;
    int   recv_idle_pct = 75;
    int   quiet_cycles  = 0;
    int   items_sent    = 0;
    cfg_t active_cfg;

    detector_coincidence_builder dut (.*);

    coincidence_checker checker_i (.*);

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("detector_coincidence_builder regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_hit(input logic [CH_W-1:0] ch, input logic [EN_W-1:0] en,
                            input logic [TS_W-1:0] ts, input logic [CFD_W-1:0] cfd,
                            input logic fin);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        hit_channel   <= ch;
        hit_energy    <= en;
        hit_timestamp <= ts;
        hit_cfd       <= cfd;
        last_hit      <= fin;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // hold off until every record is out and the sequencer has gone quiet
    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (records_outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_setting(input cfg_t s);
        logic [CFG_DATA_W-1:0] data;
        logic [3:0]            pad;
        for (int r = 0; r < NUM_REGS; r++)
        begin
            pad = 4'($urandom);
            case (cfg_reg_e'(r))
                REG_DET_BASE: data = {pad, s.det_base};
                REG_REF_A_CH: data = {pad, s.ref_a_ch};
                REG_REF_B_CH: data = {pad, s.ref_b_ch};
                REG_WIN_A_LO: data = s.win_a_lo;
                REG_WIN_A_HI: data = s.win_a_hi;
                REG_WIN_B_LO: data = s.win_b_lo;
                REG_WIN_B_HI: data = s.win_b_hi;
                default:      data = CFG_DATA_W'($urandom);
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(r);
            cfg_data  <= data;
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid  <= 1'b0;
        active_cfg = s;
    endtask

    function automatic cfg_t random_setting();
        cfg_t s;
        s.det_base = CH_W'($urandom);
        s.ref_a_ch = ($urandom_range(0, 3) == 0)
                   ? CH_W'(s.det_base + $urandom_range(0, NUM_DETECTORS_DEF - 1))
                   : CH_W'($urandom);
        s.ref_b_ch = ($urandom_range(0, 3) == 0) ? s.ref_a_ch : CH_W'($urandom);
        s.win_a_lo = WIN_W'($urandom_range(0, 200)) - WIN_W'(150);
        s.win_a_hi = s.win_a_lo + WIN_W'($urandom_range(0, 150));
        s.win_b_lo = WIN_W'($urandom_range(0, 200)) - WIN_W'(150);
        s.win_b_hi = s.win_b_lo + WIN_W'($urandom_range(0, 150));
        if ($urandom_range(0, 3) == 0)
        begin
            s.win_a_lo = WIN_W'($urandom);
            s.win_a_hi = WIN_W'($urandom);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            s.win_b_lo = WIN_W'($urandom);
            s.win_b_hi = WIN_W'($urandom);
        end
        return s;
    endfunction

    task automatic run_event();
        int               mode;
        int               hits;
        int               pick;
        logic [TS_W-1:0]  t0;
        logic [CH_W-1:0]  ch;
        logic [EN_W-1:0]  en;
        logic [TS_W-1:0]  ts;
        logic [CFD_W-1:0] cfd;
        logic             fin;
        mode = $urandom_range(0, 9);
        hits = $urandom_range(1, 12);
        t0   = TS_W'({$urandom, $urandom});
        for (int h = 0; h < hits; h++)
        begin
            if (mode == 0)
            begin
                ch  = CH_W'($urandom);
                en  = EN_W'($urandom);
                ts  = TS_W'({$urandom, $urandom});
                cfd = CFD_W'($urandom);
                fin = ($urandom_range(0, 3) == 0) || (h == hits - 1);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    ch = CH_W'(active_cfg.det_base + $urandom_range(0, NUM_DETECTORS_DEF - 1));
                else if (pick < 65)
                    ch = active_cfg.ref_a_ch;
                else if (pick < 80)
                    ch = active_cfg.ref_b_ch;
                else if (pick < 90)
                    ch = pick[0] ? CH_W'(active_cfg.det_base - 1)
                                 : CH_W'(active_cfg.det_base + NUM_DETECTORS_DEF);
                else
                    ch = CH_W'($urandom);
                pick = $urandom_range(0, 19);
                en = (pick < 3) ? '0 : (pick == 3) ? '1 : EN_W'($urandom);
                if (mode < 7)
                begin
                    ts  = t0 + TS_W'($urandom_range(0, 120));
                    cfd = CFD_W'($urandom_range(0, 40));
                end
                else
                begin
                    ts  = TS_W'({$urandom, $urandom});
                    cfd = CFD_W'($urandom);
                end
                fin = (h == hits - 1);
            end
            items_sent++;
            send_hit(ch, en, ts, cfd, fin);
        end
    endtask

    initial
    begin
        active_cfg = '{DET_BASE_RST, REF_A_CH_RST, REF_B_CH_RST,
                       WIN_A_LO_RST, WIN_A_HI_RST, WIN_B_LO_RST, WIN_B_HI_RST};
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes, channels just outside the range, repeated detector
        send_hit(12'd600, 16'hFFFF, 48'd0, 16'd0, 1'b0);
        send_hit(12'd403, 16'd1, 48'd30, 16'd0, 1'b0);
        send_hit(12'd503, 16'hFFFF, 48'd0, 16'hFFFF, 1'b0);
        send_hit(12'd609, 16'd0, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b0);
        send_hit(12'd610, 16'd5, 48'd10, 16'd0, 1'b0);
        send_hit(12'd599, 16'd5, 48'd10, 16'd0, 1'b0);
        send_hit(12'd600, 16'd77, 48'd5, 16'd0, 1'b0);
        send_hit(12'd4095, 16'd9, 48'd0, 16'd0, 1'b1);
        // reference whose first hit carries no energy
        send_hit(12'd403, 16'd0, 48'd100, 16'd0, 1'b0);
        send_hit(12'd403, 16'd50, 48'd100, 16'd0, 1'b0);
        send_hit(12'd605, 16'd0, 48'd120, 16'd0, 1'b0);
        send_hit(12'd503, 16'd9, 48'd60, 16'd0, 1'b0);
        send_hit(12'd0, 16'd3, 48'd0, 16'd0, 1'b1);
        // event without any detector
        send_hit(12'd403, 16'd4, 48'd1, 16'd0, 1'b1);
        // window boundaries
        send_hit(12'd403, 16'd10, 48'd1000, 16'd0, 1'b0);
        send_hit(12'd503, 16'd20, 48'd1000, 16'd0, 1'b0);
        send_hit(12'd603, 16'd31, 48'd1060, 16'd0, 1'b0);
        send_hit(12'd604, 16'd32, 48'd1010, 16'd0, 1'b0);
        send_hit(12'd605, 16'd33, 48'd1061, 16'd0, 1'b0);
        send_hit(12'd606, 16'd34, 48'd1009, 16'd0, 1'b0);
        send_hit(12'd607, 16'd35, 48'd900, 16'd40, 1'b0);
        send_hit(12'd608, 16'd36, 48'd939, 16'd0, 1'b1);
        // saturation both ways
        send_hit(12'd601, 16'd41, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b0);
        send_hit(12'd602, 16'd42, 48'd0, 16'd0, 1'b0);
        send_hit(12'd403, 16'd43, 48'd0, 16'd0, 1'b0);
        send_hit(12'd503, 16'd44, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b1);
        wait_idle();

        for (int s = 0; s < SECTIONS; s++)
        begin
            case (s)
                0:       apply_setting(WIDE_SETTING);
                1:       apply_setting(TOP_SETTING);
                2:       apply_setting(EDGE_SETTING);
                default: apply_setting(random_setting());
            endcase
            send_idle_pct = (s < 3) ? 10 : (s < 6) ? 75 : 0;
            recv_idle_pct = (s < 3) ? 75 : (s < 6) ? 10 : 0;
            items_sent = 0;
            while (items_sent < SECTION_ITEMS)
                run_event();
            wait_idle();
        end

        if (mismatch_count == 0 && records_outstanding == 0)
            $display("detector_coincidence_builder regression: pass");
        else
            $display("detector_coincidence_builder regression: fail");
        $finish;
    end

endmodule

/* detector_coincidence_builder.f */
+incdir+rtl
rtl/dcb_pkg.sv
rtl/dcb_front.sv
rtl/dcb_queue.sv
rtl/dcb_back.sv
rtl/detector_coincidence_builder.sv
tb/sv/dcb_tb_pkg.sv
tb/sv/coincidence_checker.sv
tb/sv/testbench.sv
